[rtl/lfr_pkg.sv]
`default_nettype none

package lfr_pkg;

   localparam int TABLE_DEPTH   = 55;
   localparam int SHORT_LAG     = 24;
   localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
   localparam int PARTNER_RESET = 31;
   localparam int LAG_GAP       = TABLE_DEPTH - SHORT_LAG;

   localparam int WORD_BITS_DEF = 30;
   localparam int DROP_BITS_DEF = 6;
   localparam int SEED_BITS     = 30;
   localparam int VALUE_BITS    = 32;
   localparam int ALU_BITS      = VALUE_BITS + 1;

   localparam int REJECT_LIMIT  = 4096;
   localparam int TRY_BITS      = $clog2(REJECT_LIMIT);

   localparam int REQ_BITS      = 72;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic REG_SEED = 1'b0;

   localparam logic [1:0] OP_SEED  = 2'd0;
   localparam logic [1:0] OP_RANGE = 2'd1;
   localparam logic [1:0] OP_BITS  = 2'd2;

   typedef struct packed {
      logic [ALU_BITS-1:0] a;
      logic [ALU_BITS-1:0] b;
      logic                cin;
   } alu_req_type;

   // all ones up to and including the top set bit of d
   function automatic logic [VALUE_BITS-1:0] span_mask(input logic [VALUE_BITS-1:0] d);
      logic [VALUE_BITS-1:0] m;
      m = d;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      return m;
   endfunction

   function automatic logic [VALUE_BITS-1:0] low_mask(input logic [4:0] n);
      logic [VALUE_BITS-1:0] m;
      for (int i = 0; i < VALUE_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[rtl/lfr_alu.sv]
`default_nettype none

module lfr_alu (
   input  var lfr_pkg::alu_req_type          req,
   output logic [lfr_pkg::ALU_BITS-1:0]      sum
);
   import lfr_pkg::*;

   assign sum = req.a + req.b + ALU_BITS'(req.cin);

endmodule

`default_nettype wire

[rtl/lfr_table.sv]
`default_nettype none

module lfr_table #(
   parameter int DEPTH = lfr_pkg::TABLE_DEPTH,
   parameter int WIDTH = lfr_pkg::WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [WIDTH-1:0] q0_ff;
   logic [WIDTH-1:0] q1_ff;
   logic             v0_ff;
   logic             v1_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         v0_ff    <= valid_ff[rd_addr0];
         v1_ff    <= valid_ff[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q0_ff <= mem[rd_addr0];
      q1_ff <= mem[rd_addr1];
   end

   // an entry not written since reset reads as zero
   assign rd_data0 = v0_ff ? q0_ff : '0;
   assign rd_data1 = v1_ff ? q1_ff : '0;

endmodule

`default_nettype wire

[rtl/lagged_fibonacci_range_rng.sv]
`default_nettype none

// Channel  Dir  Transfer on                  Payload
// req      in   req_tvalid & req_tready      operation, range_low, range_high, bit_count
// rsp      out  rsp_tvalid & rsp_tready      value
// csr      in   psel & penable & pwrite      seed at byte address 0
//
// One item at a time; req_tready is high only while the sequencer is idle.
// Bits draw: read, add, done. Reseed: one table entry per cycle.
// Range draw: span, read, then add and check for each try, a fallback step if
// the reject limit is reached, finish and done; an empty or single span goes
// straight to done. Each try uses the shared adder on the registered table read.
// A held result stalls only the completion of the next item, not its accept.
// Synchronous reset clears the table through per-entry valid bits at once.
module lagged_fibonacci_range_rng #(
   parameter int WORD_BITS = lfr_pkg::WORD_BITS_DEF,
   parameter int DROP_BITS = lfr_pkg::DROP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // [1:0] operation, [33:2] range_low, [65:34] range_high, [70:66] bit_count
   input  logic [lfr_pkg::REQ_BITS-1:0]        req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value
   output logic [lfr_pkg::VALUE_BITS-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lfr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lfr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import lfr_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SPAN   = 9'b000000010,
      ST_RD     = 9'b000000100,
      ST_ADD    = 9'b000001000,
      ST_CHECK  = 9'b000010000,
      ST_FALL   = 9'b000100000,
      ST_FINISH = 9'b001000000,
      ST_SEED   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [VALUE_BITS-1:0]   lo_ff, lo_in;
   logic [VALUE_BITS-1:0]   hi_ff, hi_in;
   logic [4:0]              nbits_ff, nbits_in;
   logic [IDX_BITS-1:0]     widx_ff, widx_in;
   logic [IDX_BITS-1:0]     pidx_ff, pidx_in;
   logic [IDX_BITS-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]    prev1_ff, prev1_in;
   logic [WORD_BITS-1:0]    prev2_ff, prev2_in;
   logic [VALUE_BITS-1:0]   mask_ff, mask_in;
   logic [VALUE_BITS-1:0]   diff_ff, diff_in;
   logic [VALUE_BITS-1:0]   cand_ff, cand_in;
   logic [VALUE_BITS-1:0]   offset_ff, offset_in;
   logic [TRY_BITS-1:0]     tries_ff, tries_in;
   logic [VALUE_BITS-1:0]   result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [SEED_BITS-1:0]    seed_ff, seed_in;

   alu_req_type             alu_req;
   logic [ALU_BITS-1:0]     alu_sum;
   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   logic [WORD_BITS-1:0]    wr_data;
   logic [WORD_BITS-1:0]    rd_data0;
   logic [WORD_BITS-1:0]    rd_data1;
   logic [WORD_BITS-1:0]    sum_word;
   logic [VALUE_BITS-1:0]   draw_val;
   logic                    csr_write;

   lfr_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   lfr_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (widx_ff),
      .rd_addr1 (pidx_ff),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_in    = (csr_write && csr_paddr[2] == REG_SEED)
                       ? csr_pwdata[SEED_BITS-1:0] : seed_ff;
   assign csr_prdata = (csr_paddr[2] == REG_SEED) ? CSR_DATA_BITS'(seed_ff) : '0;

   assign sum_word = alu_sum[WORD_BITS-1:0];
   assign draw_val = VALUE_BITS'(sum_word[WORD_BITS-1:DROP_BITS]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      nbits_in     = nbits_ff;
      widx_in      = widx_ff;
      pidx_in      = pidx_ff;
      cnt_in       = cnt_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      mask_in      = mask_ff;
      diff_in      = diff_ff;
      cand_in      = cand_ff;
      offset_in    = offset_ff;
      tries_in     = tries_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      alu_req      = '0;
      wr_en        = 1'b0;
      wr_addr      = widx_ff;
      wr_data      = sum_word;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[1:0];
               lo_in    = req_tdata[33:2];
               hi_in    = req_tdata[65:34];
               nbits_in = req_tdata[70:66];
               unique case (req_tdata[1:0])
                  OP_SEED: begin
                     cnt_in   = '0;
                     state_in = ST_SEED;
                  end
                  OP_RANGE: state_in = ST_SPAN;
                  OP_BITS:  state_in = ST_RD;
                  default: begin
                     result_in = '0;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_SPAN: begin
            // exact hi - lo on sign-extended operands
            alu_req.a   = {hi_ff[VALUE_BITS-1], hi_ff};
            alu_req.b   = ~{lo_ff[VALUE_BITS-1], lo_ff};
            alu_req.cin = 1'b1;
            if (alu_sum[ALU_BITS-1] || alu_sum == '0) begin
               result_in = lo_ff;
               state_in  = ST_DONE;
            end else begin
               diff_in  = alu_sum[VALUE_BITS-1:0];
               mask_in  = span_mask(alu_sum[VALUE_BITS-1:0]);
               tries_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            alu_req.a = ALU_BITS'(rd_data0);
            alu_req.b = ALU_BITS'(rd_data1);
            wr_en     = 1'b1;
            widx_in   = (widx_ff == IDX_BITS'(TABLE_DEPTH - 1)) ? '0 : widx_ff + IDX_BITS'(1);
            pidx_in   = (pidx_ff == IDX_BITS'(TABLE_DEPTH - 1)) ? '0 : pidx_ff + IDX_BITS'(1);
            if (op_ff == OP_BITS) begin
               result_in = draw_val & low_mask(nbits_ff);
               state_in  = ST_DONE;
            end else begin
               cand_in  = draw_val & mask_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // borrow of diff - cand means cand is past the span
            alu_req.a   = {1'b0, diff_ff};
            alu_req.b   = ~{1'b0, cand_ff};
            alu_req.cin = 1'b1;
            if (!alu_sum[ALU_BITS-1]) begin
               offset_in = cand_ff;
               state_in  = ST_FINISH;
            end else if (tries_ff == TRY_BITS'(REJECT_LIMIT - 1)) begin
               state_in = ST_FALL;
            end else begin
               tries_in = tries_ff + TRY_BITS'(1);
               state_in = ST_ADD;
            end
         end
         ST_FALL: begin
            // cand - span, as cand + ~diff
            alu_req.a = {1'b0, cand_ff};
            alu_req.b = {1'b0, ~diff_ff};
            offset_in = alu_sum[VALUE_BITS-1:0];
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            alu_req.a = {1'b0, lo_ff};
            alu_req.b = {1'b0, offset_ff};
            result_in = alu_sum[VALUE_BITS-1:0];
            state_in  = ST_DONE;
         end
         ST_SEED: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == '0) begin
               wr_data = WORD_BITS'(seed_ff);
            end else if (cnt_ff == IDX_BITS'(1)) begin
               wr_data = WORD_BITS'(1);
            end else begin
               alu_req.a = ALU_BITS'(prev1_ff);
               alu_req.b = ALU_BITS'(prev2_ff);
               wr_data   = sum_word;
            end
            prev2_in = prev1_ff;
            prev1_in = wr_data;
            if (cnt_ff == IDX_BITS'(TABLE_DEPTH - 1)) begin
               widx_in   = '0;
               pidx_in   = IDX_BITS'(LAG_GAP);
               result_in = '0;
               state_in  = ST_DONE;
            end else begin
               cnt_in = cnt_ff + IDX_BITS'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         widx_ff      <= '0;
         pidx_ff      <= IDX_BITS'(PARTNER_RESET);
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         pidx_ff      <= pidx_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      nbits_ff    <= nbits_in;
      cnt_ff      <= cnt_in;
      prev1_ff    <= prev1_in;
      prev2_ff    <= prev2_in;
      mask_ff     <= mask_in;
      diff_ff     <= diff_in;
      cand_ff     <= cand_in;
      offset_ff   <= offset_in;
      tries_ff    <= tries_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[rtl/lfr_checker.sv]
`default_nettype none

module lfr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [lfr_pkg::VALUE_BITS-1:0] rsp_tdata,
   input  logic                           csr_pready
);

   // a result waiting on the consumer must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // one item at a time: busy right after a req transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while busy");

   // a new result appears exactly when the sequencer returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $rose(req_tready))
      else $error("rsp raised outside completion");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind lagged_fibonacci_range_rng lfr_checker u_lfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

`default_nettype wire
